### hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, constants and controller/datapath interface structs for the
// surface ripple spring simulation core.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int MIN_COLUMNS = 2;
    localparam int COL_W       = $clog2(MAX_COLUMNS);

    localparam int DATA_W      = 32;
    localparam int IDX_OUT_W   = 5;
    localparam int MAXH_W      = 31;
    localparam int BASE_W      = 12;
    localparam int COUNT_W     = 6;
    localparam int GAIN_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int BOUNCE_LSB  = 20;
    localparam int BOUNCE_W    = DATA_W - BOUNCE_LSB;
    localparam int LOC_W       = BASE_W + 2;

    localparam logic [BASE_W-1:0]  BASE_RESET        = 12'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET       = 6'd32;
    localparam logic [GAIN_W-1:0]  CENTER_GAIN_RESET = 8'h80;
    localparam logic [GAIN_W-1:0]  SIDE_GAIN_RESET   = 8'h99;
    localparam logic [DATA_W-1:0]  ROUND_HALF_COL    = 32'h0008_0000;
    localparam logic [DATA_W-1:0]  EDGE_OFFSET       = 32'h0008_0000;
    localparam logic [DATA_W-1:0]  EDGE_FALLBACK     = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_COLUMN  = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_CENTER_GAIN  = 2'd2,
        CFG_SIDE_GAIN    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_IMPACT = 1'b1
    } item_cmd_t;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] impact_x;
        logic signed [31:0] impact_velocity;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] column_index;
        logic signed [31:0]   surface_height;
        logic signed [31:0]   lower_edge;
        logic [MAXH_W-1:0]    max_height;
        logic                 impact_hit;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IMP_START,
        ST_IMP_ADD,
        ST_IMP_EMIT,
        ST_P1,
        ST_P2_OWN,
        ST_P2_PREV,
        ST_P2_NEXT,
        ST_P2_WR,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_IMP_ADD,
        OP_EMIT_IMP,
        OP_P1,
        OP_P2_OWN,
        OP_P2_PREV,
        OP_P2_NEXT,
        OP_P2_WR,
        OP_EMIT_TICK
    } dp_op_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LO,
        IDX_INC
    } idx_op_t;

    typedef struct packed {
        dp_op_t  op;
        idx_op_t idx_op;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic idx_last;
        logic idx_hi;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/srs_datapath.sv
// ----------------------------------------------------------------------------
// srs_datapath
// Configuration registers, column height/velocity/sum stores, impact decode,
// spring and smoothing arithmetic, and the result register.
// ----------------------------------------------------------------------------
module srs_datapath
    import srs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  in_item_t              in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic [BASE_W-1:0]  base_column_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic [GAIN_W-1:0]  center_gain_reg;
    logic [GAIN_W-1:0]  side_gain_reg;

    logic [DATA_W-1:0] h_mem [MAX_COLUMNS];
    logic [DATA_W-1:0] v_mem [MAX_COLUMNS];
    logic [DATA_W-1:0] s_mem [MAX_COLUMNS];

    logic [COL_W-1:0]  idx_reg, idx_next;
    logic [COL_W-1:0]  lo_reg, hi_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] imp_reg;
    logic [DATA_W-1:0] own_reg;
    logic [DATA_W-1:0] sum_reg;
    logic [MAXH_W-1:0] maxh_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [COL_W-1:0]    last_idx;
    logic [DATA_W-1:0]   x_round;
    logic [BOUNCE_W-1:0] bounce;
    logic [LOC_W-1:0]    loc;
    logic [LOC_W-1:0]    last_ext;
    logic                hit_calc;
    logic [COL_W-1:0]    loc_col;
    logic [COL_W-1:0]    lo_calc, hi_calc;

    logic [DATA_W-1:0] h_rd, v_rd, s_rd;
    logic [COL_W-1:0]  s_addr;
    logic [DATA_W-1:0] v_spring, s_spring;
    logic [DATA_W-1:0] own_prod, side_prod, h_new;
    logic [DATA_W-1:0] edge_a, edge_val;
    logic [MAXH_W-1:0] maxh_new;
    logic              emit;
    out_item_t         out_next;

    // active column range
    always_comb
    begin
        if (column_count_reg < COUNT_W'(MIN_COLUMNS))
            last_idx = COL_W'(MIN_COLUMNS - 1);
        else if (32'(column_count_reg) > 32'(MAX_COLUMNS))
            last_idx = COL_W'(MAX_COLUMNS - 1);
        else
            last_idx = COL_W'(column_count_reg - COUNT_W'(1));
    end

    // impact decode
    always_comb
    begin
        x_round  = in_data.impact_x + ROUND_HALF_COL;
        bounce   = x_round[DATA_W-1:BOUNCE_LSB];
        loc      = {{(LOC_W-BOUNCE_W){bounce[BOUNCE_W-1]}}, bounce}
                   - {{(LOC_W-BASE_W){1'b0}}, base_column_reg};
        last_ext = LOC_W'(last_idx);
        hit_calc = !loc[LOC_W-1] && (loc != '0) && (loc <= last_ext);
        loc_col  = COL_W'(loc);
        lo_calc  = (loc_col == COL_W'(1)) ? COL_W'(1) : loc_col - COL_W'(1);
        hi_calc  = (loc_col == last_idx) ? last_idx : loc_col + COL_W'(1);
    end

    // store reads
    always_comb
    begin
        case (cmd.op)
            OP_P2_PREV: s_addr = (idx_reg == '0) ? '0 : idx_reg - COL_W'(1);
            OP_P2_NEXT: s_addr = (idx_reg == last_idx) ? last_idx : idx_reg + COL_W'(1);
            default:    s_addr = idx_reg;
        endcase
        h_rd = h_mem[idx_reg];
        v_rd = v_mem[idx_reg];
        s_rd = s_mem[s_addr];
    end

    // spring, smoothing and edge arithmetic
    always_comb
    begin
        v_spring  = v_rd + DATA_W'($signed(DATA_W'(0) - h_rd) >>> 5)
                    - DATA_W'($signed(v_rd) >>> 3);
        s_spring  = v_spring + h_rd;
        own_prod  = s_rd * {{(DATA_W-GAIN_W){1'b0}}, center_gain_reg};
        side_prod = sum_reg * {{(DATA_W-GAIN_W){1'b0}}, side_gain_reg};
        h_new     = own_reg + DATA_W'($signed(side_prod) >>> 9);
        edge_a    = {h_rd[DATA_W-2:0], 1'b0} + EDGE_OFFSET;
        edge_val  = ($signed(edge_a) < $signed(h_rd)) ? h_rd + EDGE_FALLBACK : edge_a;
        if (idx_reg == '0)
            maxh_new = h_rd[DATA_W-1] ? '0 : h_rd[MAXH_W-1:0];
        else if (!h_rd[DATA_W-1] && (h_rd[MAXH_W-1:0] > maxh_reg))
            maxh_new = h_rd[MAXH_W-1:0];
        else
            maxh_new = maxh_reg;
    end

    // index counter
    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_LO:   idx_next = lo_reg;
            IDX_INC:  idx_next = idx_reg + COL_W'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    // result beat
    always_comb
    begin
        emit     = (cmd.op == OP_EMIT_TICK) || (cmd.op == OP_EMIT_IMP);
        out_next = '0;
        if (cmd.op == OP_EMIT_TICK)
        begin
            out_next.column_index   = IDX_OUT_W'(idx_reg);
            out_next.surface_height = h_rd;
            out_next.lower_edge     = edge_val;
            out_next.max_height     = maxh_new;
            out_next.last           = (idx_reg == last_idx);
        end
        else
        begin
            out_next.impact_hit = hit_reg;
            out_next.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_column_reg  <= BASE_RESET;
            column_count_reg <= COUNT_RESET;
            center_gain_reg  <= CENTER_GAIN_RESET;
            side_gain_reg    <= SIDE_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_COLUMN:  base_column_reg  <= cfg_data[BASE_W-1:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_CENTER_GAIN:  center_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_SIDE_GAIN:    side_gain_reg    <= cfg_data[GAIN_W-1:0];
                default:          base_column_reg  <= base_column_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_COLUMNS; k++)
            begin
                h_mem[k] <= '0;
                v_mem[k] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_P1:      v_mem[idx_reg] <= v_spring;
                OP_IMP_ADD: v_mem[idx_reg] <= v_rd + imp_reg;
                OP_P2_WR:   h_mem[idx_reg] <= h_new;
                default:    h_mem[idx_reg] <= h_mem[idx_reg];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_P1)
            s_mem[idx_reg] <= s_spring;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.op == OP_CAPTURE)
                hit_reg <= hit_calc;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            lo_reg  <= lo_calc;
            hi_reg  <= hi_calc;
            imp_reg <= in_data.impact_velocity;
        end
        if (cmd.op == OP_P2_OWN)
            own_reg <= DATA_W'($signed(own_prod) >>> 8);
        if (cmd.op == OP_P2_PREV)
            sum_reg <= s_rd;
        if (cmd.op == OP_P2_NEXT)
            sum_reg <= sum_reg + s_rd;
        if (cmd.op == OP_EMIT_TICK)
            maxh_reg <= maxh_new;
        if (emit)
            out_reg <= out_next;
    end

    assign status.hit      = hit_reg;
    assign status.idx_last = (idx_reg == last_idx);
    assign status.idx_hi   = (idx_reg == hi_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    property p_emit_into_free;
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT_TICK || cmd.op == OP_EMIT_IMP) |-> status.out_free;
    endproperty
    a_emit_into_free: assert property (p_emit_into_free)
        else $error("result beat issued while output register is held");

    property p_impact_in_range;
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_IMP_ADD) |-> (hit_reg && idx_reg >= lo_reg && idx_reg <= hi_reg
                                    && idx_reg != '0 && idx_reg <= last_idx);
    endproperty
    a_impact_in_range: assert property (p_impact_in_range)
        else $error("impulse applied outside interior columns");

    property p_tick_index_bound;
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_P1 || cmd.op == OP_P2_WR || cmd.op == OP_EMIT_TICK)
            |-> idx_reg <= last_idx;
    endproperty
    a_tick_index_bound: assert property (p_tick_index_bound)
        else $error("tick pass beyond active columns");

    property p_emit_shows;
        @(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT_TICK || cmd.op == OP_EMIT_IMP) |=> out_valid_reg;
    endproperty
    a_emit_shows: assert property (p_emit_shows)
        else $error("issued result beat not presented");

endmodule

### hdl/srs_ctrl.sv
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer for impact updates and the three tick passes (spring update,
// gain smoothing, result readout).
// ----------------------------------------------------------------------------
module srs_ctrl
    import srs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (in_cmd == CMD_IMPACT) ? ST_IMP_START : ST_P1;
            ST_IMP_START:
                state_next = status.hit ? ST_IMP_ADD : ST_IMP_EMIT;
            ST_IMP_ADD:
                if (status.idx_hi)
                    state_next = ST_IMP_EMIT;
            ST_IMP_EMIT:
                if (status.out_free)
                    state_next = ST_IDLE;
            ST_P1:
                if (status.idx_last)
                    state_next = ST_P2_OWN;
            ST_P2_OWN:
                state_next = ST_P2_PREV;
            ST_P2_PREV:
                state_next = ST_P2_NEXT;
            ST_P2_NEXT:
                state_next = ST_P2_WR;
            ST_P2_WR:
                state_next = status.idx_last ? ST_OUT : ST_P2_OWN;
            ST_OUT:
                if (status.out_free && status.idx_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op     = OP_NOP;
        cmd.idx_op = IDX_HOLD;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    cmd.idx_op = IDX_ZERO;
                end
            end
            ST_IMP_START:
                cmd.idx_op = IDX_LO;
            ST_IMP_ADD:
            begin
                cmd.op     = OP_IMP_ADD;
                cmd.idx_op = status.idx_hi ? IDX_HOLD : IDX_INC;
            end
            ST_IMP_EMIT:
                if (status.out_free)
                    cmd.op = OP_EMIT_IMP;
            ST_P1:
            begin
                cmd.op     = OP_P1;
                cmd.idx_op = status.idx_last ? IDX_ZERO : IDX_INC;
            end
            ST_P2_OWN:
                cmd.op = OP_P2_OWN;
            ST_P2_PREV:
                cmd.op = OP_P2_PREV;
            ST_P2_NEXT:
                cmd.op = OP_P2_NEXT;
            ST_P2_WR:
            begin
                cmd.op     = OP_P2_WR;
                cmd.idx_op = status.idx_last ? IDX_ZERO : IDX_INC;
            end
            ST_OUT:
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT_TICK;
                    cmd.idx_op = status.idx_last ? IDX_HOLD : IDX_INC;
                end
            default:
                cmd.op = OP_NOP;
        endcase
    end

endmodule

### hdl/surface_ripple_spring_sim_core.sv
// ----------------------------------------------------------------------------
// surface_ripple_spring_sim_core
// Water surface spring simulation over up to MAX_COLUMNS columns: impacts
// add impulse around a column, ticks run spring feedback and smoothing and
// stream one result beat per active column.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall  | in_item_t (cmd, impact x, impulse)
//   out     | output    | out_valid/out_stall| out_item_t (one per column or impact)
//   cfg     | input     | cfg_valid/cfg_ready| register index + data
//
// Impact: up to three velocity adds lie between accept and result beat.
// Tick: the single read port of the scratch sum store sets the four
// smoothing steps per column (own sum, previous sum, next sum, height write).
// Out stalls extend the readout pass; the next item is accepted once the last
// result beat sits in the output register.
// Reset clears all heights and velocities and loads register defaults.
// ----------------------------------------------------------------------------
module surface_ripple_spring_sim_core
    import srs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    srs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### tb/surface_ripple_spring_sim_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// surface_ripple_spring_sim_core_test
// Self-checking regression for the surface ripple spring core. A local
// predictor of column heights and velocities computes every result beat of
// each accepted impact or tick, and a checker compares the beats that leave
// the core field by field. Directed items cover the range edges of impacts,
// register masking and count saturation; random phases with fresh register
// settings, bursty input and patterned output stalls follow, together with
// one long output hold-off that backs the core up into its input.
// ----------------------------------------------------------------------------
module surface_ripple_spring_sim_core_test;
    import srs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 300;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PRINT_CAP     = 60;
    localparam int          RAND_PHASES   = 6;
    localparam int          PHASE_ITEMS   = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_beat;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    surface_ripple_spring_sim_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted surface state and register copies
    logic [31:0]         col_vel [MAX_COLUMNS];
    logic [31:0]         col_hgt [MAX_COLUMNS];
    logic [31:0]         col_sum [MAX_COLUMNS];
    logic [BASE_W-1:0]   base_q;
    logic [COUNT_W-1:0]  count_q;
    logic [GAIN_W-1:0]   cgain_q;
    logic [GAIN_W-1:0]   sgain_q;

    out_item_t   pending_beats[$];
    int          error_count = 0;
    int          burst_left  = 0;
    int unsigned cycle_count = 0;

    logic        hold_on    = 1'b0;
    int          stall_mode = 0;
    int          mode_left  = 0;
    int          stall_tick = 0;
    event        hold_start;

    function automatic logic [31:0] shift_floor(input logic [31:0] u, input int s);
        return $signed(u) >>> s;
    endfunction

    function automatic int active_columns();
        int n;
        n = int'(count_q);
        if (n < MIN_COLUMNS)
            n = MIN_COLUMNS;
        if (n > MAX_COLUMNS)
            n = MAX_COLUMNS;
        return n;
    endfunction

    task automatic advance_surface(input in_item_t item);
        int          n;
        int          bounce;
        int          loc;
        int          lo;
        int          hi;
        int          p;
        int          q;
        int          maxh;
        int          hs;
        logic [31:0] sum;
        logic [31:0] h;
        logic [31:0] v;
        logic [31:0] own;
        logic [31:0] side;
        logic [31:0] lo_edge;
        out_item_t   b;
        n = active_columns();
        if (item.cmd == CMD_IMPACT)
        begin
            sum    = item.impact_x + ROUND_HALF_COL;
            bounce = $signed(sum) >>> BOUNCE_LSB;
            loc    = bounce - int'(base_q);
            b      = '0;
            b.last = 1'b1;
            if (loc >= 1 && loc <= n - 1)
            begin
                lo = (loc - 1 < 1) ? 1 : loc - 1;
                hi = (loc + 1 > n - 1) ? n - 1 : loc + 1;
                for (int i = lo; i <= hi; i++)
                    col_vel[i] = col_vel[i] + item.impact_velocity;
                b.impact_hit = 1'b1;
            end
            pending_beats.push_back(b);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                h = col_hgt[i];
                v = col_vel[i];
                v = v + shift_floor(32'd0 - h, 5) - shift_floor(v, 3);
                col_vel[i] = v;
                col_sum[i] = v + h;
            end
            for (int i = 0; i < n; i++)
            begin
                p = (i > 0) ? i - 1 : 0;
                q = (i + 1 < n) ? i + 1 : n - 1;
                own  = {24'd0, cgain_q} * col_sum[i];
                side = {24'd0, sgain_q} * (col_sum[p] + col_sum[q]);
                col_hgt[i] = shift_floor(own, 8) + shift_floor(side, 9);
            end
            maxh = 0;
            for (int i = 0; i < n; i++)
            begin
                h  = col_hgt[i];
                hs = $signed(h);
                if (hs > maxh)
                    maxh = hs;
                lo_edge = 2 * h + EDGE_OFFSET;
                if ($signed(lo_edge) < hs)
                    lo_edge = h + EDGE_FALLBACK;
                b                = '0;
                b.column_index   = i[IDX_OUT_W-1:0];
                b.surface_height = h;
                b.lower_edge     = lo_edge;
                b.max_height     = maxh[MAXH_W-1:0];
                b.last           = (i == n - 1);
                pending_beats.push_back(b);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (pending_beats.size() == 0)
        begin
            report_mismatch("unexpected beat", got.surface_height, 32'd0);
        end
        else
        begin
            want = pending_beats.pop_front();
            if (got.column_index !== want.column_index)
                report_mismatch("column_index", 32'(got.column_index),
                                32'(want.column_index));
            if (got.surface_height !== want.surface_height)
                report_mismatch("surface_height", got.surface_height, want.surface_height);
            if (got.lower_edge !== want.lower_edge)
                report_mismatch("lower_edge", got.lower_edge, want.lower_edge);
            if (got.max_height !== want.max_height)
                report_mismatch("max_height", 32'(got.max_height), 32'(want.max_height));
            if (got.impact_hit !== want.impact_hit)
                report_mismatch("impact_hit", 32'(got.impact_hit), 32'(want.impact_hit));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            check_beat(out_beat);
    end

    // output stall pattern, overridden by the long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(10, 200);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            stall_tick <= stall_tick + 1;
            if (hold_on)
                out_stall <= 1'b1;
            else
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ((stall_tick % 7) < 3);
                endcase
        end
    end

    initial
    begin
        forever
        begin
            @(hold_start);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("surface_ripple_spring_sim_core regression: fail");
        $finish;
    end

    task automatic send_item(input in_item_t item);
        int  gap;
        logic taken;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        advance_surface(item);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_COLUMN:  base_q  = val[BASE_W-1:0];
            CFG_COLUMN_COUNT: count_q = val[COUNT_W-1:0];
            CFG_CENTER_GAIN:  cgain_q = val[GAIN_W-1:0];
            CFG_SIDE_GAIN:    sgain_q = val[GAIN_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] aim_x(input int local_col, input logic [19:0] frac);
        logic [31:0] col;
        col = int'(base_q) + local_col;
        return (col << BOUNCE_LSB) - ROUND_HALF_COL + {12'd0, frac};
    endfunction

    function automatic in_item_t impact_item(input logic [31:0] x, input logic [31:0] v);
        in_item_t it;
        it.cmd             = CMD_IMPACT;
        it.impact_x        = x;
        it.impact_velocity = v;
        return it;
    endfunction

    function automatic in_item_t tick_item();
        in_item_t it;
        it.cmd             = CMD_TICK;
        it.impact_x        = $urandom;
        it.impact_velocity = $urandom;
        return it;
    endfunction

    task automatic test_reset_state();
        send_item(tick_item());
        wait_idle();
    endtask

    task automatic test_impact_range();
        send_item(impact_item(aim_x(0, 20'h8_0000), 32'h0001_0000));
        send_item(impact_item(aim_x(1, 20'hF_FFFF), 32'h7FFF_FFFF));
        send_item(impact_item(aim_x(31, 20'h0_0000), 32'h8000_0000));
        send_item(impact_item(aim_x(32, 20'h0_0000), 32'h0000_0001));
        send_item(impact_item(aim_x(16, 20'h4_0000), 32'hFFFD_0000));
        send_item(impact_item(32'hFFF7_FFFF, 32'h0002_0000));
        send_item(impact_item(32'h7FFF_FFFF, 32'h0002_0000));
        send_item(impact_item(32'h8000_0000, 32'hFFFF_FFFF));
        send_item(tick_item());
        send_item(tick_item());
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_COLUMN_COUNT, 12'h000);
        send_item(tick_item());
        wait_idle();
        write_reg(CFG_COLUMN_COUNT, 12'hFC1);
        send_item(impact_item(aim_x(1, 20'h1_2345), 32'h0004_0000));
        send_item(impact_item(aim_x(2, 20'h0_0000), 32'h0004_0000));
        send_item(tick_item());
        wait_idle();
        write_reg(CFG_COLUMN_COUNT, 12'h03F);
        write_reg(CFG_CENTER_GAIN, 12'hFFF);
        write_reg(CFG_SIDE_GAIN, 12'hFFF);
        send_item(tick_item());
        wait_idle();
        write_reg(CFG_COLUMN_COUNT, 12'h021);
        write_reg(CFG_CENTER_GAIN, 12'hF00);
        write_reg(CFG_SIDE_GAIN, 12'h000);
        send_item(tick_item());
        wait_idle();
        write_reg(CFG_BASE_COLUMN, 12'hFFF);
        send_item(impact_item(32'h7FF0_0000, 32'h0001_0000));
        wait_idle();
        write_reg(CFG_BASE_COLUMN, 12'h005);
        write_reg(CFG_COLUMN_COUNT, 12'h003);
        write_reg(CFG_CENTER_GAIN, 12'h080);
        write_reg(CFG_SIDE_GAIN, 12'h099);
        send_item(impact_item(aim_x(1, 20'h7_7777), 32'h0003_0000));
        send_item(tick_item());
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_BASE_COLUMN, 12'h000);
        write_reg(CFG_COLUMN_COUNT, 12'h020);
        -> hold_start;
        for (int k = 0; k < 6; k++)
            send_item((k % 2 == 0) ? tick_item()
                      : impact_item(aim_x($urandom_range(1, 31), 20'($urandom)), $urandom));
        wait_idle();
    endtask

    task automatic test_random_phases();
        int       n;
        int       sel;
        logic [31:0] v;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(CFG_BASE_COLUMN, 12'(($urandom_range(0, 3) == 0)
                      ? $urandom_range(0, 4095) : $urandom_range(0, 40)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_COLUMN_COUNT, 12'd2);
                1: write_reg(CFG_COLUMN_COUNT, 12'd32);
                2: write_reg(CFG_COLUMN_COUNT, 12'($urandom_range(0, 4095)));
                default: write_reg(CFG_COLUMN_COUNT, 12'($urandom_range(3, 31)));
            endcase
            write_reg(CFG_CENTER_GAIN, 12'($urandom_range(0, 4095)));
            write_reg(CFG_SIDE_GAIN, 12'($urandom_range(0, 4095)));
            n = active_columns();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                begin
                    v = ($urandom_range(0, 4) == 0) ? $urandom
                        : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                    send_item(impact_item(aim_x($urandom_range(0, n), 20'($urandom)), v));
                end
                else if (sel < 5)
                begin
                    send_item(impact_item($urandom, $urandom));
                end
                else
                begin
                    send_item(tick_item());
                end
            end
            wait_idle();
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            col_vel[i] = '0;
            col_hgt[i] = '0;
            col_sum[i] = '0;
        end
        base_q  = BASE_RESET;
        count_q = COUNT_RESET;
        cgain_q = CENTER_GAIN_RESET;
        sgain_q = SIDE_GAIN_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_impact_range();
        test_register_extremes();
        test_output_backpressure();
        test_random_phases();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_beats.size() == 0)
            $display("surface_ripple_spring_sim_core regression: pass");
        else
            $display("surface_ripple_spring_sim_core regression: fail");
        $finish;
    end

endmodule
